>>> hdl/mobb_pkg.sv
// ----------------------------------------------------------------------------
// mobb_pkg
// shared types and constants of the monthly ohlcv bar builder
// ----------------------------------------------------------------------------
package mobb_pkg;

    localparam int DATE_W   = 27;
    localparam int PRICE_W  = 31;
    localparam int DAMT_W   = 48;
    localparam int DVOL_W   = 40;
    localparam int BAMT_W   = 40;
    localparam int BVOL_W   = 32;
    localparam int DAYS_W   = 5;
    localparam int KEY_W    = 20;
    localparam int IN_W     = 240;
    localparam int OUT_W    = 232;

    localparam int MONTH_DIV  = 100;
    localparam int AMOUNT_DIV = 100000;
    localparam int VOLUME_DIV = 10000;

    // divisors split into a power of two and an odd part
    localparam int DATE_SH  = 2;
    localparam int DATE_OD  = MONTH_DIV / 4;
    localparam int AMT_SH   = 5;
    localparam int AMT_OD   = AMOUNT_DIV / 32;
    localparam int VOL_SH   = 4;
    localparam int VOL_OD   = VOLUME_DIV / 16;

    localparam int DATE_QW = $clog2(((64'd1 << (DATE_W - DATE_SH)) / DATE_OD) + 1);
    localparam int AMT_QW  = $clog2(((64'd1 << (DAMT_W - AMT_SH)) / AMT_OD) + 1);
    localparam int VOL_QW  = $clog2(((64'd1 << (DVOL_W - VOL_SH)) / VOL_OD) + 1);

    localparam logic [DAYS_W-1:0] DAYS_MAX = 5'd31;

    typedef struct packed {
        logic [DATE_W-1:0]  date;
        logic [PRICE_W-1:0] open;
        logic [PRICE_W-1:0] high;
        logic [PRICE_W-1:0] low;
        logic [PRICE_W-1:0] close;
        logic               eos;
    } t_day;

    typedef struct packed {
        logic [DATE_W-1:0]  date;
        logic [PRICE_W-1:0] open;
        logic [PRICE_W-1:0] high;
        logic [PRICE_W-1:0] low;
        logic [PRICE_W-1:0] close;
        logic [BAMT_W-1:0]  amount;
        logic [BVOL_W-1:0]  volume;
        logic [DAYS_W-1:0]  days;
        logic               last;
    } t_bar;

endpackage

>>> hdl/monthly_ohlcv_bar_builder_core.sv
// ----------------------------------------------------------------------------
// monthly_ohlcv_bar_builder_core
// builds monthly ohlcv bars from a stream of daily price records
// ----------------------------------------------------------------------------
// Takes one daily beat per clock cycle while o_s_tready is high. Each beat
// passes a three stage constant divider (month key, turnover and volume
// scaling) and is folded into the open bar as it leaves the third stage; a
// finished bar is then written to the queue and shown from there on the output.
// A beat causes zero, one or two bars (month change and, with tlast, the
// flush of the open bar). Bars wait in a four entry queue; the input stalls
// only while that queue holds more than two bars, so the rate is one day
// per cycle as long as the output side keeps pace with the bar rate.
module monthly_ohlcv_bar_builder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // day_date, day_open, day_high, day_low, day_close, day_amount,
    // day_volume, one pad bit
    input  logic [mobb_pkg::IN_W-1:0]   i_s_tdata,
    input  logic                        i_s_tlast,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // bar_date, bar_open, bar_high, bar_low, bar_close, bar_amount,
    // bar_volume, bar_days, four pad bits
    output logic [mobb_pkg::OUT_W-1:0]  o_m_tdata,
    output logic                        o_m_tlast
);
    import mobb_pkg::*;

    logic                r_v1;
    logic                r_v2;
    logic                r_v3;
    t_day                r_day1;
    t_day                r_day2;
    t_day                r_day3;
    t_day                w_day;
    logic                w_adv;
    logic                w_room;
    logic                w_take;
    logic [DATE_QW-1:0]  w_month;
    logic [AMT_QW-1:0]   w_amt;
    logic [VOL_QW-1:0]   w_vol;
    logic [1:0]          w_push_n;
    t_bar                w_res0;
    t_bar                w_res1;
    t_bar                w_head;

    assign w_day.date  = i_s_tdata[26:0];
    assign w_day.open  = i_s_tdata[57:27];
    assign w_day.high  = i_s_tdata[88:58];
    assign w_day.low   = i_s_tdata[119:89];
    assign w_day.close = i_s_tdata[150:120];
    assign w_day.eos   = i_s_tlast;

    assign w_adv      = !r_v3 || w_room;
    assign w_take     = r_v3 && w_room;
    assign o_s_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_day1 <= w_day;
            r_day2 <= r_day1;
            r_day3 <= r_day2;
        end
    end

    mobb_cdiv #(
        .P_IW (DATE_W),
        .P_SH (DATE_SH),
        .P_D  (DATE_OD),
        .P_QW (DATE_QW)
    ) u_div_date (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_din (i_s_tdata[26:0]),
        .o_quo (w_month)
    );

    mobb_cdiv #(
        .P_IW (DAMT_W),
        .P_SH (AMT_SH),
        .P_D  (AMT_OD),
        .P_QW (AMT_QW)
    ) u_div_amt (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_din (i_s_tdata[198:151]),
        .o_quo (w_amt)
    );

    mobb_cdiv #(
        .P_IW (DVOL_W),
        .P_SH (VOL_SH),
        .P_D  (VOL_OD),
        .P_QW (VOL_QW)
    ) u_div_vol (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_din (i_s_tdata[238:199]),
        .o_quo (w_vol)
    );

    mobb_fold u_fold (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_day    (r_day3),
        .i_key    (w_month[KEY_W-1:0]),
        .i_amt    (w_amt),
        .i_vol    (w_vol),
        .o_push_n (w_push_n),
        .o_res0   (w_res0),
        .o_res1   (w_res1)
    );

    mobb_rfifo u_rfifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_res0   (w_res0),
        .i_res1   (w_res1),
        .i_pop    (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_head   (w_head),
        .o_room   (w_room)
    );

    assign o_m_tdata = {4'd0, w_head.days, w_head.volume, w_head.amount, w_head.close,
                        w_head.low, w_head.high, w_head.open, w_head.date};
    assign o_m_tlast = w_head.last;

endmodule

>>> hdl/mobb_cdiv.sv
// ----------------------------------------------------------------------------
// mobb_cdiv
// three stage divider by a constant: reciprocal multiply and one correction
// ----------------------------------------------------------------------------
module mobb_cdiv #(
    parameter int P_IW = 48,
    parameter int P_SH = 5,
    parameter int P_D  = 3125,
    parameter int P_QW = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [P_IW-1:0]  i_din,
    output logic [P_QW-1:0]  o_quo
);

    localparam int XW = P_IW - P_SH;
    localparam int LW = (XW + 1) / 2;
    localparam int HW = XW - LW;
    localparam int RW = $clog2(2 * P_D);
    localparam logic [63:0]     MFULL = (64'd1 << XW) / P_D;
    localparam logic [P_QW-1:0] MUL   = MFULL[P_QW-1:0];
    localparam logic [RW-1:0]   DIV_R = RW'(P_D);

    logic [XW-1:0]        w_x;
    logic [LW+P_QW-1:0]   r_plo;
    logic [HW+P_QW-1:0]   r_phi;
    logic [RW-1:0]        r_xl1;
    logic [XW+P_QW-1:0]   w_sum;
    logic [P_QW-1:0]      r_q0;
    logic [RW-1:0]        r_xl2;
    logic [RW-1:0]        w_prod;
    logic [RW-1:0]        w_rem;
    logic [P_QW-1:0]      r_quo;

    assign w_x = i_din[P_IW-1:P_SH];

    // split partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo <= (LW+P_QW)'(w_x[LW-1:0]) * (LW+P_QW)'(MUL);
            r_phi <= (HW+P_QW)'(w_x[XW-1:LW]) * (HW+P_QW)'(MUL);
            r_xl1 <= w_x[RW-1:0];
        end
    end

    assign w_sum = {r_phi, {LW{1'b0}}} + (XW+P_QW)'(r_plo);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0  <= w_sum[XW+P_QW-1:XW];
            r_xl2 <= r_xl1;
        end
    end

    // estimate is exact or one low; remainder fits in rw bits
    assign w_prod = RW'(r_q0[RW-1:0] * DIV_R);
    assign w_rem  = r_xl2 - w_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= (w_rem >= DIV_R) ? r_q0 + 1'b1 : r_q0;
        end
    end

    assign o_quo = r_quo;

endmodule

>>> hdl/mobb_fold.sv
// ----------------------------------------------------------------------------
// mobb_fold
// open bar state: folds one day in, emits finished and flushed bars
// ----------------------------------------------------------------------------
module mobb_fold (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  mobb_pkg::t_day                i_day,
    input  logic [mobb_pkg::KEY_W-1:0]    i_key,
    input  logic [mobb_pkg::AMT_QW-1:0]   i_amt,
    input  logic [mobb_pkg::VOL_QW-1:0]   i_vol,
    output logic [1:0]                    o_push_n,
    output mobb_pkg::t_bar                o_res0,
    output mobb_pkg::t_bar                o_res1
);
    import mobb_pkg::*;

    logic                r_active;
    logic [KEY_W-1:0]    r_key;
    t_bar                r_bar;
    t_bar                n_bar;
    logic                w_close_old;
    logic                w_start;
    logic [BAMT_W:0]     w_amt_sum;
    logic [BVOL_W:0]     w_vol_sum;
    logic [BAMT_W-1:0]   w_amt_base;
    logic [BVOL_W-1:0]   w_vol_base;
    t_bar                w_old;

    assign w_close_old = r_active && (i_key != r_key);
    assign w_start     = !r_active || w_close_old;
    assign w_amt_base  = w_start ? '0 : r_bar.amount;
    assign w_vol_base  = w_start ? '0 : r_bar.volume;
    assign w_amt_sum   = {1'b0, w_amt_base} + (BAMT_W+1)'(i_amt);
    assign w_vol_sum   = {1'b0, w_vol_base} + (BVOL_W+1)'(i_vol);

    always_comb begin
        n_bar.date   = i_day.date;
        n_bar.close  = i_day.close;
        n_bar.amount = w_amt_sum[BAMT_W] ? '1 : w_amt_sum[BAMT_W-1:0];
        n_bar.volume = w_vol_sum[BVOL_W] ? '1 : w_vol_sum[BVOL_W-1:0];
        n_bar.last   = 1'b1;
        if (w_start) begin
            n_bar.open = i_day.open;
            n_bar.high = i_day.high;
            n_bar.low  = i_day.low;
            n_bar.days = DAYS_W'(1);
        end else begin
            n_bar.open = r_bar.open;
            n_bar.high = (i_day.high > r_bar.high) ? i_day.high : r_bar.high;
            n_bar.low  = (i_day.low < r_bar.low) ? i_day.low : r_bar.low;
            n_bar.days = (r_bar.days < DAYS_MAX) ? r_bar.days + 1'b1 : DAYS_MAX;
        end
    end

    always_comb begin
        w_old      = r_bar;
        w_old.last = !i_day.eos;
    end

    assign o_res0   = w_close_old ? w_old : n_bar;
    assign o_res1   = n_bar;
    assign o_push_n = i_take ? (2'(w_close_old) + 2'(i_day.eos)) : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_take) begin
            r_active <= !i_day.eos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_key <= i_key;
            r_bar <= n_bar;
        end
    end

endmodule

>>> hdl/mobb_rfifo.sv
// ----------------------------------------------------------------------------
// mobb_rfifo
// four entry result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module mobb_rfifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_n,
    input  mobb_pkg::t_bar    i_res0,
    input  mobb_pkg::t_bar    i_res1,
    input  logic              i_pop,
    output logic              o_valid,
    output mobb_pkg::t_bar    o_head,
    output logic              o_room
);
    import mobb_pkg::*;

    t_bar        r_mem [4];
    logic [1:0]  r_wp;
    logic [1:0]  r_rp;
    logic [2:0]  r_cnt;
    logic        w_pop;

    assign o_valid = (r_cnt != 3'd0);
    assign o_head  = r_mem[r_rp];
    assign o_room  = (r_cnt <= 3'd2);
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + i_push_n;
            r_rp  <= r_rp + 2'(w_pop);
            r_cnt <= r_cnt + 3'(i_push_n) - 3'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_res1;
        end
    end

endmodule

>>> hdl/mobb_checker.sv
// ----------------------------------------------------------------------------
// mobb_checker
// port level checks of the monthly bar builder
// ----------------------------------------------------------------------------
module mobb_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [mobb_pkg::OUT_W-1:0]  i_m_tdata,
    input  logic                        i_m_tlast
);

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("bar beat right after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
            && $stable(i_m_tlast))
        else $error("bar beat changed while stalled");

    a_days_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[227:223] != 5'd0)
        else $error("bar with zero days");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tready && !i_m_tlast |=> i_m_tvalid)
        else $error("second bar of a pair missing");

endmodule

bind monthly_ohlcv_bar_builder_core mobb_checker u_mobb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tlast  (o_m_tlast)
);
